/* rtl/core/partition_table_checker_macros.svh */
// Assertion macros for the partition table checker.
// Used by rtl/core/partition_table_checker.sv; expects clk and arst_n in scope.
`ifndef PARTITION_TABLE_CHECKER_MACROS_SVH
`define PARTITION_TABLE_CHECKER_MACROS_SVH

// same-cycle implication
`define PTC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define PTC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/core/ptc_pkg.sv */
// Types, codes and the key slot table for the partition table checker.
// No dependencies; used by rtl/core/partition_table_checker.sv.
`default_nettype none

package ptc_pkg;

	typedef struct packed {
		logic [7:0]  fs_type;
		logic [7:0]  crypto_type;
		logic [31:0] part_offset;
		logic [31:0] part_size;
		logic        header_ok;
		logic [31:0] image_size;
	} in_item_t;

	typedef struct packed {
		logic        header_valid;
		logic [32:0] min_size;
		logic [1:0]  lookup_status;
		logic [31:0] found_sector;
		logic [32:0] found_count;
		logic [7:0]  found_keyslot;
	} out_item_t;

	typedef enum logic [1:0] {
		LS_FOUND    = 2'd0,
		LS_REJECTED = 2'd1,
		LS_NO_MATCH = 2'd2
	} lookup_status_t;

	typedef enum logic [1:0] {
		REG_QUERY_TYPE    = 2'd0,
		REG_QUERY_SUBTYPE = 2'd1,
		REG_QUERY_INDEX   = 2'd2
	} cfg_reg_t;

	localparam logic [3:0] QTYPE_NONE     = 4'd0;
	localparam logic [3:0] QTYPE_STANDARD = 4'd1;
	localparam logic [3:0] QTYPE_RESERVED = 4'd2;
	localparam logic [3:0] QTYPE_FIRM     = 4'd3;
	localparam logic [3:0] QTYPE_SAVE     = 4'd4;
	localparam logic [3:0] QSUB_MAX       = 4'd3;

	localparam logic [7:0] FS_TYPE_NONE = 8'h00;
	localparam logic [7:0] FS_TYPE_FIRM = 8'h03;
	localparam logic [7:0] SLOT_NONE    = 8'hFF;

	localparam int CFG_DATA_W = 4;

	// key slot by query type and subtype; SLOT_NONE where the table has no slot
	function automatic logic [7:0] key_slot(input logic [3:0] qt, input logic [3:0] qs);
		logic [7:0] slot;
		slot = SLOT_NONE;
		if (qt == QTYPE_STANDARD || qt == QTYPE_RESERVED) begin
			unique case (qs)
				4'd1:    slot = 8'h03;
				4'd2:    slot = 8'h04;
				4'd3:    slot = 8'h05;
				default: slot = SLOT_NONE;
			endcase
		end else if (qt == QTYPE_FIRM && qs == 4'd2) begin
			slot = 8'h06;
		end else if (qt == QTYPE_SAVE && qs == 4'd2) begin
			slot = 8'h11 - 8'h0A;
		end
		return slot;
	endfunction

endpackage

`default_nettype wire

/* rtl/core/partition_table_checker.sv */
// Partition table checker: one header entry in per item, one verdict item out per header.
// Depends on rtl/core/ptc_pkg.sv and rtl/core/partition_table_checker_macros.svh.
// Rate: one entry per cycle while entry_stall is low. Each entry is registered on arrival
// (its end sum computed there), then folded into the running header state; the last entry
// of a header also loads the result register. A header's last entry passes the entry
// register and then the result register, and a stall can hold it between the two. The entry
// side stalls only while a finished verdict waits in the result register and the last
// entry of the next header is ready to fold.
`default_nettype none

`include "partition_table_checker_macros.svh"

module partition_table_checker #(
	parameter int ENTRY_COUNT = 8
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               entry_valid,
	output logic                              entry_stall,
	input  wire ptc_pkg::in_item_t            entry,
	output logic                              result_valid,
	input  wire                               result_stall,
	output ptc_pkg::out_item_t                result,
	input  wire                               cfg_wr_en,
	input  wire [1:0]                         cfg_index,
	input  wire [ptc_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int CNT_W = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;
	localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(ENTRY_COUNT - 1);

	// configuration
	logic [3:0] query_type_q;
	logic [3:0] query_subtype_q;
	logic [2:0] query_index_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			query_type_q    <= ptc_pkg::QTYPE_STANDARD;
			query_subtype_q <= '0;
			query_index_q   <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				ptc_pkg::REG_QUERY_TYPE:    query_type_q    <= cfg_data[3:0];
				ptc_pkg::REG_QUERY_SUBTYPE: query_subtype_q <= cfg_data[3:0];
				ptc_pkg::REG_QUERY_INDEX:   query_index_q   <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	// input stage
	logic              valid_s1;
	ptc_pkg::in_item_t item_s1;
	logic [32:0]       end_s1;
	logic [CNT_W-1:0]  cnt_q;
	logic              last_s1;
	logic              out_free;
	logic              adv;
	logic              in_take;

	assign last_s1     = (cnt_q >= LAST_IDX);
	assign out_free    = !result_valid || !result_stall;
	assign adv         = valid_s1 && (!last_s1 || out_free);
	assign entry_stall = valid_s1 && !adv;
	assign in_take     = entry_valid && !entry_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv || !valid_s1) begin
			valid_s1 <= in_take;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			item_s1 <= entry;
			end_s1  <= {1'b0, entry.part_offset} + {1'b0, entry.part_size};
		end
	end

	// header state
	logic        fail_q, any_typed_q, firm_seen_q, found_flag_q;
	logic [32:0] prev_end_q, max_end_q;
	logic [2:0]  matches_left_q;
	logic [31:0] found_offset_q, found_length_q;

	logic        fail_d, any_typed_d, firm_seen_d, found_flag_d;
	logic [32:0] prev_end_d, max_end_d;
	logic [2:0]  matches_left_d;
	logic [31:0] found_offset_d, found_length_d;
	logic        first;
	logic        is_match;
	logic        rejected;
	ptc_pkg::out_item_t res_d;

	assign first    = (cnt_q == '0);
	assign is_match = (item_s1.fs_type == {4'b0, query_type_q})
		&& (item_s1.crypto_type == {4'b0, query_subtype_q});
	assign rejected = (query_type_q == ptc_pkg::QTYPE_RESERVED)
		|| (query_type_q > ptc_pkg::QTYPE_SAVE) || (query_subtype_q > ptc_pkg::QSUB_MAX);

	always_comb begin
		if (first) begin
			fail_d         = !item_s1.header_ok;
			any_typed_d    = 1'b0;
			prev_end_d     = '0;
			firm_seen_d    = 1'b0;
			max_end_d      = '0;
			matches_left_d = query_index_q;
			found_flag_d   = 1'b0;
			found_offset_d = '0;
			found_length_d = '0;
		end else begin
			fail_d         = fail_q;
			any_typed_d    = any_typed_q;
			prev_end_d     = prev_end_q;
			firm_seen_d    = firm_seen_q;
			max_end_d      = max_end_q;
			matches_left_d = matches_left_q;
			found_flag_d   = found_flag_q;
			found_offset_d = found_offset_q;
			found_length_d = found_length_q;
		end

		if (item_s1.fs_type != ptc_pkg::FS_TYPE_NONE) any_typed_d = 1'b1;
		if (end_s1 > max_end_d) max_end_d = end_s1;

		if (item_s1.part_size == '0) begin
			if (first) fail_d = 1'b1;
		end else begin
			if (item_s1.fs_type == ptc_pkg::FS_TYPE_NONE) fail_d = 1'b1;
			if ({1'b0, item_s1.part_offset} < prev_end_d) fail_d = 1'b1;
			prev_end_d = end_s1;
			if (item_s1.fs_type == ptc_pkg::FS_TYPE_FIRM) firm_seen_d = 1'b1;
		end

		if (!found_flag_d && is_match) begin
			if (matches_left_d == '0) begin
				found_flag_d   = 1'b1;
				found_offset_d = item_s1.part_offset;
				found_length_d = item_s1.part_size;
			end else begin
				matches_left_d = matches_left_d - 3'd1;
			end
		end

		res_d.header_valid  = !fail_d && any_typed_d && firm_seen_d
			&& (prev_end_d <= {1'b0, item_s1.image_size});
		res_d.min_size      = max_end_d;
		res_d.lookup_status = ptc_pkg::LS_NO_MATCH;
		res_d.found_sector  = '0;
		res_d.found_count   = '0;
		res_d.found_keyslot = ptc_pkg::SLOT_NONE;
		priority if (rejected) begin
			res_d.lookup_status = ptc_pkg::LS_REJECTED;
		end else if (query_type_q == ptc_pkg::QTYPE_NONE) begin
			res_d.lookup_status = ptc_pkg::LS_FOUND;
			res_d.found_count   = max_end_d;
		end else if (found_flag_d) begin
			res_d.lookup_status = ptc_pkg::LS_FOUND;
			res_d.found_sector  = found_offset_d;
			res_d.found_count   = {1'b0, found_length_d};
			res_d.found_keyslot = ptc_pkg::key_slot(query_type_q, query_subtype_q);
		end else begin
			res_d.lookup_status = ptc_pkg::LS_NO_MATCH;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q          <= '0;
			fail_q         <= 1'b0;
			any_typed_q    <= 1'b0;
			prev_end_q     <= '0;
			firm_seen_q    <= 1'b0;
			max_end_q      <= '0;
			matches_left_q <= '0;
			found_flag_q   <= 1'b0;
			found_offset_q <= '0;
			found_length_q <= '0;
		end else if (adv) begin
			cnt_q          <= last_s1 ? '0 : CNT_W'(cnt_q + 1'b1);
			fail_q         <= fail_d;
			any_typed_q    <= any_typed_d;
			prev_end_q     <= prev_end_d;
			firm_seen_q    <= firm_seen_d;
			max_end_q      <= max_end_d;
			matches_left_q <= matches_left_d;
			found_flag_q   <= found_flag_d;
			found_offset_q <= found_offset_d;
			found_length_q <= found_length_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (out_free) begin
			result_valid <= adv && last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && last_s1) begin
			result <= res_d;
		end
	end

	`PTC_ASSERT_NOW(a_stall_needs_entry, entry_stall, valid_s1 && last_s1, "stall without held last entry")
	`PTC_ASSERT_NEXT(a_cnt_wraps, adv && last_s1, cnt_q == '0, "entry count not cleared after header")
	`PTC_ASSERT_NEXT(a_cnt_steps, adv && !last_s1, cnt_q == CNT_W'($past(cnt_q) + 1'b1), "entry count did not step")
	`PTC_ASSERT_NOW(a_slot_only_found, result_valid && result.lookup_status != ptc_pkg::LS_FOUND, result.found_keyslot == ptc_pkg::SLOT_NONE && result.found_sector == '0, "lookup fields set without a hit")

endmodule

`default_nettype wire
